// ----- hw/rtl/rtu_pkg.sv -----
package rtu_pkg;

  // Default sizing of the table
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned IfaceCountDef   = 16;
  localparam int unsigned RefBitsDef      = 16;

  // Fixed field widths of the transaction ports
  localparam int unsigned KindW   = 2;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned IfaceW  = 4;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 16;

  // Request kinds
  typedef enum logic [KindW-1:0] {
    KindSearch  = 2'd0,
    KindAdd     = 2'd1,
    KindAddDef  = 2'd2,
    KindRelease = 2'd3
  } kind_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusNone  = 2'd1,
    StatusUnref = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    CtrlIdle,
    CtrlWalk,
    CtrlWrite
  } ctrl_e;

  // Update command broadcast from the sequencer to the cells
  typedef struct packed {
    logic refs_we;       // overwrite the reference count of the addressed slot
    logic fill_we;       // fill the addressed slot with the held route
    logic fill_default;  // the filled route is a default route
  } rtu_upd_t;

endpackage

// ----- hw/rtl/rtu_cell.sv -----
module rtu_cell import rtu_pkg::*; #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned REF_W    = RefBitsDef,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // held request
  input  logic [AddrW-1:0]  dest_addr_i,
  input  logic [AddrW-1:0]  net_mask_i,
  input  logic [IfaceW-1:0] iface_id_i,
  input  logic              iface_loopback_i,
  input  logic [SlotW-1:0]  slot_in_i,
  // update command
  input  rtu_upd_t          upd_i,
  input  logic [IDX_W-1:0]  upd_idx_i,
  input  logic [REF_W-1:0]  upd_refs_i,
  // wave from the previous cell
  input  logic              vld_i,
  input  logic              hit_vld_i,
  input  logic [IDX_W-1:0]  hit_idx_i,
  input  logic [IfaceW-1:0] hit_iface_i,
  input  logic [REF_W-1:0]  hit_refs_i,
  input  logic              def_vld_i,
  input  logic [IDX_W-1:0]  def_idx_i,
  input  logic [IfaceW-1:0] def_iface_i,
  input  logic [REF_W-1:0]  def_refs_i,
  input  logic              free_vld_i,
  input  logic [IDX_W-1:0]  free_idx_i,
  input  logic [REF_W-1:0]  rel_refs_i,
  input  logic              ext_i,
  // wave to the next cell
  output logic              vld_o,
  output logic              hit_vld_o,
  output logic [IDX_W-1:0]  hit_idx_o,
  output logic [IfaceW-1:0] hit_iface_o,
  output logic [REF_W-1:0]  hit_refs_o,
  output logic              def_vld_o,
  output logic [IDX_W-1:0]  def_idx_o,
  output logic [IfaceW-1:0] def_iface_o,
  output logic [REF_W-1:0]  def_refs_o,
  output logic              free_vld_o,
  output logic [IDX_W-1:0]  free_idx_o,
  output logic [REF_W-1:0]  rel_refs_o,
  output logic              ext_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(CELL_IDX);

  // Entry state
  logic              up_q, dflt_q;
  logic [AddrW-1:0]  dest_q, mask_q;
  logic [IfaceW-1:0] iface_q;
  logic              loop_q;
  logic [REF_W-1:0]  refs_q;

  // Wave registers
  logic              vld_q, hit_vld_q, def_vld_q, free_vld_q, ext_q;
  logic [IDX_W-1:0]  hit_idx_q, def_idx_q, free_idx_q;
  logic [IfaceW-1:0] hit_iface_q, def_iface_q;
  logic [REF_W-1:0]  hit_refs_q, def_refs_q, rel_refs_q;

  logic sel, match, is_free, is_rel;

  assign sel     = (upd_idx_i == MyIdx);
  assign match   = up_q && !dflt_q && ((dest_addr_i & mask_q) == dest_q);
  assign is_free = !up_q && !dflt_q && (refs_q == '0);
  assign is_rel  = (32'(slot_in_i) == CELL_IDX);

  // Hold the entry flags and count; apply the addressed update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q   <= 1'b0;
      dflt_q <= 1'b0;
      refs_q <= '0;
    end else if (sel && upd_i.fill_we) begin
      up_q   <= 1'b1;
      dflt_q <= upd_i.fill_default;
      refs_q <= '0;
    end else if (sel && upd_i.refs_we) begin
      refs_q <= upd_refs_i;
    end
  end

  // Route payload, written on fill only
  always_ff @(posedge clk_i) begin
    if (sel && upd_i.fill_we) begin
      dest_q  <= dest_addr_i;
      mask_q  <= upd_i.fill_default ? '0 : net_mask_i;
      iface_q <= iface_id_i;
      loop_q  <= iface_loopback_i;
    end
  end

  // Advance the wave valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Merge this entry into the wave and pass it on
  always_ff @(posedge clk_i) begin
    hit_vld_q   <= hit_vld_i || match;
    hit_idx_q   <= hit_vld_i ? hit_idx_i   : MyIdx;
    hit_iface_q <= hit_vld_i ? hit_iface_i : iface_q;
    hit_refs_q  <= hit_vld_i ? hit_refs_i  : refs_q;
    // last up default wins
    def_vld_q   <= def_vld_i || (up_q && dflt_q);
    def_idx_q   <= (up_q && dflt_q) ? MyIdx   : def_idx_i;
    def_iface_q <= (up_q && dflt_q) ? iface_q : def_iface_i;
    def_refs_q  <= (up_q && dflt_q) ? refs_q  : def_refs_i;
    // first never-used slot wins
    free_vld_q  <= free_vld_i || is_free;
    free_idx_q  <= free_vld_i ? free_idx_i : MyIdx;
    rel_refs_q  <= is_rel ? refs_q : rel_refs_i;
    ext_q       <= ext_i || (up_q && !loop_q);
  end

  assign vld_o       = vld_q;
  assign hit_vld_o   = hit_vld_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_iface_o = hit_iface_q;
  assign hit_refs_o  = hit_refs_q;
  assign def_vld_o   = def_vld_q;
  assign def_idx_o   = def_idx_q;
  assign def_iface_o = def_iface_q;
  assign def_refs_o  = def_refs_q;
  assign free_vld_o  = free_vld_q;
  assign free_idx_o  = free_idx_q;
  assign rel_refs_o  = rel_refs_q;
  assign ext_o       = ext_q;

endmodule

// ----- hw/rtl/rtu_ctrl.sv -----
module rtu_ctrl import rtu_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned IFACE_COUNT   = IfaceCountDef,
  parameter int unsigned IDX_W         = 4,
  parameter int unsigned REF_W         = RefBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input transaction
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [AddrW-1:0]   dest_addr_i,
  input  logic [AddrW-1:0]   net_mask_i,
  input  logic [IfaceW-1:0]  iface_id_i,
  input  logic               iface_loopback_i,
  input  logic [SlotW-1:0]   slot_in_i,
  // held request to the cells
  output logic [AddrW-1:0]   req_dest_o,
  output logic [AddrW-1:0]   req_mask_o,
  output logic [IfaceW-1:0]  req_iface_o,
  output logic               req_loop_o,
  output logic [SlotW-1:0]   req_slot_o,
  output logic               wave_start_o,
  // update command to the cells
  output rtu_upd_t           upd_o,
  output logic [IDX_W-1:0]   upd_idx_o,
  output logic [REF_W-1:0]   upd_refs_o,
  // wave leaving the last cell
  input  logic               w_vld_i,
  input  logic               w_hit_vld_i,
  input  logic [IDX_W-1:0]   w_hit_idx_i,
  input  logic [IfaceW-1:0]  w_hit_iface_i,
  input  logic [REF_W-1:0]   w_hit_refs_i,
  input  logic               w_def_vld_i,
  input  logic [IDX_W-1:0]   w_def_idx_i,
  input  logic [IfaceW-1:0]  w_def_iface_i,
  input  logic [REF_W-1:0]   w_def_refs_i,
  input  logic               w_free_vld_i,
  input  logic [IDX_W-1:0]   w_free_idx_i,
  input  logic [REF_W-1:0]   w_rel_refs_i,
  input  logic               w_ext_i,
  // result transaction
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   slot_out_o,
  output logic [IfaceW-1:0]  route_iface_o,
  output logic [CountW-1:0]  ref_count_o,
  output logic               has_external_route_o
);

  ctrl_e state_q, state_d;

  // Held request
  kind_e             kind_q;
  logic [AddrW-1:0]  dest_q, mask_q;
  logic [IfaceW-1:0] iface_q;
  logic              loop_q;
  logic [SlotW-1:0]  slot_q;
  logic              start_q;

  // Decision taken from the wave
  status_e           dec_status;
  logic [IDX_W-1:0]  dec_idx;
  logic [IfaceW-1:0] dec_iface;
  logic [REF_W-1:0]  dec_refs;
  logic              dec_ext;
  rtu_upd_t          dec_upd;

  status_e           res_status_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic [IfaceW-1:0] res_iface_q;
  logic [REF_W-1:0]  res_refs_q;
  logic              res_ext_q;
  rtu_upd_t          res_upd_q;

  // Output register
  logic               out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [SlotW-1:0]   slot_out_q;
  logic [IfaceW-1:0]  route_iface_q;
  logic [CountW-1:0]  ref_count_q;
  logic               ext_q;

  logic accept, capture, out_free, retire;

  assign accept   = in_valid_i && !in_stall_o;
  assign capture  = (state_q == CtrlWalk) && w_vld_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign retire   = (state_q == CtrlWrite) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CtrlIdle:  if (in_valid_i) state_d = CtrlWalk;
      CtrlWalk:  if (w_vld_i)    state_d = CtrlWrite;
      CtrlWrite: if (out_free)   state_d = CtrlIdle;
      default:                   state_d = CtrlIdle;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o = 1'b1;
    upd_o      = '0;
    unique case (state_q)
      CtrlIdle:  in_stall_o = 1'b0;
      CtrlWalk:  in_stall_o = 1'b1;
      CtrlWrite: if (out_free) upd_o = res_upd_q;
      default:   in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtrlIdle;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_e'(kind_i);
      dest_q  <= dest_addr_i;
      mask_q  <= net_mask_i;
      iface_q <= iface_id_i;
      loop_q  <= iface_loopback_i;
      slot_q  <= slot_in_i;
    end
  end

  // Resolve the wave into a result and an update
  always_comb begin
    dec_status = StatusNone;
    dec_idx    = '0;
    dec_iface  = '0;
    dec_refs   = '0;
    dec_ext    = w_ext_i;
    dec_upd    = '0;
    unique case (kind_q)
      KindSearch: begin
        if (w_hit_vld_i || w_def_vld_i) begin
          dec_status = StatusOk;
          dec_idx    = w_hit_vld_i ? w_hit_idx_i   : w_def_idx_i;
          dec_iface  = w_hit_vld_i ? w_hit_iface_i : w_def_iface_i;
          dec_refs   = w_hit_vld_i ? w_hit_refs_i  : w_def_refs_i;
          // saturate at the top of the count
          if (dec_refs != '1) dec_refs = dec_refs + REF_W'(1);
          dec_upd.refs_we = 1'b1;
        end
      end
      KindAdd, KindAddDef: begin
        if ((32'(iface_q) < IFACE_COUNT) && w_free_vld_i) begin
          dec_status           = StatusOk;
          dec_idx              = w_free_idx_i;
          dec_upd.fill_we      = 1'b1;
          dec_upd.fill_default = (kind_q == KindAddDef);
          dec_ext              = w_ext_i || !loop_q;
        end
      end
      KindRelease: begin
        if (32'(slot_q) < TABLE_ENTRIES) begin
          dec_idx = IDX_W'(slot_q);
          if (w_rel_refs_i == '0) begin
            dec_status = StatusUnref;
          end else begin
            dec_status      = StatusOk;
            dec_refs        = w_rel_refs_i - REF_W'(1);
            dec_upd.refs_we = 1'b1;
          end
        end
      end
      default: dec_status = StatusNone;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      res_status_q <= dec_status;
      res_idx_q    <= dec_idx;
      res_iface_q  <= dec_iface;
      res_refs_q   <= dec_refs;
      res_ext_q    <= dec_ext;
      res_upd_q    <= dec_upd;
    end
  end

  // Output register: load on retire, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (retire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      status_q      <= res_status_q;
      slot_out_q    <= SlotW'(res_idx_q);
      route_iface_q <= res_iface_q;
      ref_count_q   <= CountW'(res_refs_q);
      ext_q         <= res_ext_q;
    end
  end

  assign req_dest_o           = dest_q;
  assign req_mask_o           = mask_q;
  assign req_iface_o          = iface_q;
  assign req_loop_o           = loop_q;
  assign req_slot_o           = slot_q;
  assign wave_start_o         = start_q;
  assign upd_idx_o            = res_idx_q;
  assign upd_refs_o           = res_refs_q;
  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign slot_out_o           = slot_out_q;
  assign route_iface_o        = route_iface_q;
  assign ref_count_o          = ref_count_q;
  assign has_external_route_o = ext_q;

endmodule

// ----- hw/rtl/ipv4_route_table_unit.sv -----
// IPv4 route table with masked-match lookup. Each transaction is a search, an
// add route, an add default route or a reference release, and gives exactly
// one result. The table is a row of TABLE_ENTRIES cells, one route per cell;
// a request walks the row one cell per clock, collecting the first matching
// route, the last default route, the first never-used slot and the released
// slot's count, then the sequencer writes any update back to the chosen cell.
// One transaction is in flight at a time. Its result is captured from the
// end of the cell row into a result register and then loaded into the
// output register once that is free, and the next transaction can be taken
// only after that, so the block does not take a new transaction before it
// is through with the last; in_stall_o is low only while the block is idle.
// The result sits in an output register, so a new transaction may be accepted
// while the previous result is still waiting. Release of a slot beyond the
// table and add with an out-of-range interface report no route.
module ipv4_route_table_unit import rtu_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned IFACE_COUNT   = IfaceCountDef,
  parameter int unsigned REF_BITS      = RefBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [AddrW-1:0]   dest_addr_i,
  input  logic [AddrW-1:0]   net_mask_i,
  input  logic [IfaceW-1:0]  iface_id_i,
  input  logic               iface_loopback_i,
  input  logic [SlotW-1:0]   slot_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [StatusW-1:0] status_o,
  output logic [SlotW-1:0]   slot_out_o,
  output logic [IfaceW-1:0]  route_iface_o,
  output logic [CountW-1:0]  ref_count_o,
  output logic               has_external_route_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned N    = TABLE_ENTRIES;

  logic [AddrW-1:0]  req_dest, req_mask;
  logic [IfaceW-1:0] req_iface;
  logic              req_loop;
  logic [SlotW-1:0]  req_slot;
  rtu_upd_t          upd;
  logic [IdxW-1:0]   upd_idx;
  logic [REF_BITS-1:0] upd_refs;

  // Wave links between cells; link 0 feeds the first cell
  logic                vld      [N+1];
  logic                hit_vld  [N+1];
  logic [IdxW-1:0]     hit_idx  [N+1];
  logic [IfaceW-1:0]   hit_iface[N+1];
  logic [REF_BITS-1:0] hit_refs [N+1];
  logic                def_vld  [N+1];
  logic [IdxW-1:0]     def_idx  [N+1];
  logic [IfaceW-1:0]   def_iface[N+1];
  logic [REF_BITS-1:0] def_refs [N+1];
  logic                free_vld [N+1];
  logic [IdxW-1:0]     free_idx [N+1];
  logic [REF_BITS-1:0] rel_refs [N+1];
  logic                ext      [N+1];

  // Start each wave empty
  assign hit_vld[0]   = 1'b0;
  assign hit_idx[0]   = '0;
  assign hit_iface[0] = '0;
  assign hit_refs[0]  = '0;
  assign def_vld[0]   = 1'b0;
  assign def_idx[0]   = '0;
  assign def_iface[0] = '0;
  assign def_refs[0]  = '0;
  assign free_vld[0]  = 1'b0;
  assign free_idx[0]  = '0;
  assign rel_refs[0]  = '0;
  assign ext[0]       = 1'b0;

  rtu_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IFACE_COUNT  (IFACE_COUNT),
    .IDX_W        (IdxW),
    .REF_W        (REF_BITS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .dest_addr_i,
    .net_mask_i,
    .iface_id_i,
    .iface_loopback_i,
    .slot_in_i,
    .req_dest_o   (req_dest),
    .req_mask_o   (req_mask),
    .req_iface_o  (req_iface),
    .req_loop_o   (req_loop),
    .req_slot_o   (req_slot),
    .wave_start_o (vld[0]),
    .upd_o        (upd),
    .upd_idx_o    (upd_idx),
    .upd_refs_o   (upd_refs),
    .w_vld_i      (vld[N]),
    .w_hit_vld_i  (hit_vld[N]),
    .w_hit_idx_i  (hit_idx[N]),
    .w_hit_iface_i(hit_iface[N]),
    .w_hit_refs_i (hit_refs[N]),
    .w_def_vld_i  (def_vld[N]),
    .w_def_idx_i  (def_idx[N]),
    .w_def_iface_i(def_iface[N]),
    .w_def_refs_i (def_refs[N]),
    .w_free_vld_i (free_vld[N]),
    .w_free_idx_i (free_idx[N]),
    .w_rel_refs_i (rel_refs[N]),
    .w_ext_i      (ext[N]),
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .slot_out_o,
    .route_iface_o,
    .ref_count_o,
    .has_external_route_o
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rtu_cell #(
      .IDX_W   (IdxW),
      .REF_W   (REF_BITS),
      .CELL_IDX(i)
    ) u_cell (
      .clk_i,
      .rst_ni,
      .dest_addr_i     (req_dest),
      .net_mask_i      (req_mask),
      .iface_id_i      (req_iface),
      .iface_loopback_i(req_loop),
      .slot_in_i       (req_slot),
      .upd_i           (upd),
      .upd_idx_i       (upd_idx),
      .upd_refs_i      (upd_refs),
      .vld_i           (vld[i]),
      .hit_vld_i       (hit_vld[i]),
      .hit_idx_i       (hit_idx[i]),
      .hit_iface_i     (hit_iface[i]),
      .hit_refs_i      (hit_refs[i]),
      .def_vld_i       (def_vld[i]),
      .def_idx_i       (def_idx[i]),
      .def_iface_i     (def_iface[i]),
      .def_refs_i      (def_refs[i]),
      .free_vld_i      (free_vld[i]),
      .free_idx_i      (free_idx[i]),
      .rel_refs_i      (rel_refs[i]),
      .ext_i           (ext[i]),
      .vld_o           (vld[i+1]),
      .hit_vld_o       (hit_vld[i+1]),
      .hit_idx_o       (hit_idx[i+1]),
      .hit_iface_o     (hit_iface[i+1]),
      .hit_refs_o      (hit_refs[i+1]),
      .def_vld_o       (def_vld[i+1]),
      .def_idx_o       (def_idx[i+1]),
      .def_iface_o     (def_iface[i+1]),
      .def_refs_o      (def_refs[i+1]),
      .free_vld_o      (free_vld[i+1]),
      .free_idx_o      (free_idx[i+1]),
      .rel_refs_o      (rel_refs[i+1]),
      .ext_o           (ext[i+1])
    );
  end

endmodule

// ----- hw/rtl/rtu_checker.sv -----
module rtu_checker import rtu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [StatusW-1:0] status_o,
  input logic [SlotW-1:0]   slot_out_o,
  input logic [IfaceW-1:0]  route_iface_o,
  input logic [CountW-1:0]  ref_count_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // Once a transaction is taken the block is busy with it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a transaction was taken");

  // A failed request touches no slot
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusNone) |->
      (slot_out_o == '0) && (ref_count_o == '0) && (route_iface_o == '0))
    else $error("failed request reports a slot");

  // Release of an unreferenced slot reports a zero count
  a_unref_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatusUnref) |->
      (ref_count_o == '0) && (route_iface_o == '0))
    else $error("unreferenced release with non-zero count");

endmodule

bind ipv4_route_table_unit rtu_checker u_rtu_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .out_valid_o,
  .out_stall_i,
  .status_o,
  .slot_out_o,
  .route_iface_o,
  .ref_count_o
);
